// File: rtl/core/bhq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bhq_pkg: shared types and codes of the binary min-heap queue
// Key type, operation codes and result status codes.
// ----------------------------------------------------------------------------
package bhq_pkg;

   localparam int KEY_W    = 32;
   localparam int STATUS_W = 2;

   typedef logic signed [KEY_W-1:0] key_type;
   typedef logic [STATUS_W-1:0]     status_type;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_FULL  = 2'd1;
   localparam status_type STATUS_EMPTY = 2'd2;

endpackage
`default_nettype wire

// File: rtl/core/bhq_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bhq_store: key store of the heap
// Synchronous memory, one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module bhq_store #(
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire bhq_pkg::key_type         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output bhq_pkg::key_type              rd_data
);

   bhq_pkg::key_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// File: rtl/core/binary_min_heap_queue_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// binary_min_heap_queue_unit: binary min-heap priority queue of signed keys
// Insert sifts the new key up, remove-min moves the last key to the root and
// sifts it down; each operation returns status, removed key, minimum and fill.
// ----------------------------------------------------------------------------
// One operation at a time: busy stays high from the transfer until the result
// is shown, and rsp_valid marks the result for exactly one cycle; the result
// must be taken then, it cannot be held off. A sifted key moves at most
// log2(CAPACITY) levels; a full insert or an empty remove goes straight to
// the result, and removing the last key does no sift. The pace of a sift is
// set by the single read port of the key store: each level is one read per
// key compared, then a compare and write-back. No clearing pass is needed
// after reset.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_unit #(
   parameter int CAPACITY = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_op,
   input  wire bhq_pkg::key_type              req_key,
   output logic                               rsp_valid,
   output bhq_pkg::status_type                rsp_status,
   output bhq_pkg::key_type                   rsp_removed_key,
   output bhq_pkg::key_type                   rsp_top_key,
   output logic [$clog2(CAPACITY+1)-1:0]      rsp_fill
);

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int FILL_W = $clog2(CAPACITY + 1);
   localparam int CW     = ADDR_W + 2;

   localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(CAPACITY);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_UP_RD   = 3'd1;
   localparam logic [2:0] ST_UP_CMP  = 3'd2;
   localparam logic [2:0] ST_RM_LAST = 3'd3;
   localparam logic [2:0] ST_DN_L    = 3'd4;
   localparam logic [2:0] ST_DN_R    = 3'd5;
   localparam logic [2:0] ST_DN_CMP  = 3'd6;
   localparam logic [2:0] ST_FIN     = 3'd7;

   logic [2:0]          state_ff, state_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [ADDR_W-1:0]   pos_ff, pos_in;
   bhq_pkg::key_type    key_ff, key_in;
   bhq_pkg::key_type    lval_ff, lval_in;
   logic                has_right_ff, has_right_in;
   bhq_pkg::key_type    top_ff, top_in;
   bhq_pkg::status_type status_ff, status_in;
   bhq_pkg::key_type    removed_ff, removed_in;

   logic                rsp_valid_ff, rsp_valid_in;
   bhq_pkg::status_type rsp_status_ff, rsp_status_in;
   bhq_pkg::key_type    rsp_removed_ff, rsp_removed_in;
   bhq_pkg::key_type    rsp_top_ff, rsp_top_in;
   logic [FILL_W-1:0]   rsp_fill_ff, rsp_fill_in;

   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   bhq_pkg::key_type    wr_data;
   logic [ADDR_W-1:0]   rd_addr;
   bhq_pkg::key_type    rd_data;

   logic [ADDR_W-1:0]   parent;
   logic [CW-1:0]       left_idx;
   logic [CW-1:0]       right_idx;
   logic [CW-1:0]       fill_ext;
   logic                pick_right;
   bhq_pkg::key_type    pick_val;
   logic [CW-1:0]       pick_idx;

   bhq_store #(
      .DEPTH(CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign parent     = (pos_ff - ADDR_W'(1)) >> 1;
   assign left_idx   = {1'b0, pos_ff, 1'b1};
   assign right_idx  = left_idx + CW'(1);
   assign fill_ext   = {{(CW-FILL_W){1'b0}}, fill_ff};
   assign pick_right = has_right_ff && (rd_data < lval_ff);
   assign pick_val   = pick_right ? rd_data : lval_ff;
   assign pick_idx   = pick_right ? right_idx : left_idx;

   always_comb begin
      state_in       = state_ff;
      fill_in        = fill_ff;
      pos_in         = pos_ff;
      key_in         = key_ff;
      lval_in        = lval_ff;
      has_right_in   = has_right_ff;
      status_in      = status_ff;
      removed_in     = removed_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_top_in     = rsp_top_ff;
      rsp_fill_in    = rsp_fill_ff;
      wr_en          = 1'b0;
      wr_addr        = pos_ff;
      wr_data        = key_ff;
      rd_addr        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               removed_in = '0;
               status_in  = bhq_pkg::STATUS_OK;
               if (req_op == bhq_pkg::OP_INSERT) begin
                  if (fill_ff == FILL_MAX) begin
                     status_in = bhq_pkg::STATUS_FULL;
                     state_in  = ST_FIN;
                  end else begin
                     pos_in   = fill_ff[ADDR_W-1:0];
                     key_in   = req_key;
                     fill_in  = fill_ff + FILL_W'(1);
                     state_in = ST_UP_RD;
                  end
               end else begin
                  if (fill_ff == '0) begin
                     status_in = bhq_pkg::STATUS_EMPTY;
                     state_in  = ST_FIN;
                  end else begin
                     removed_in = top_ff;
                     rd_addr    = ADDR_W'(fill_ff - FILL_W'(1));
                     fill_in    = fill_ff - FILL_W'(1);
                     state_in   = ST_RM_LAST;
                  end
               end
            end
         end
         ST_UP_RD: begin
            if (pos_ff == '0) begin
               wr_en    = 1'b1;
               state_in = ST_FIN;
            end else begin
               rd_addr  = parent;
               state_in = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            wr_en = 1'b1;
            if (rd_data > key_ff) begin
               wr_data  = rd_data;
               pos_in   = parent;
               state_in = ST_UP_RD;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_RM_LAST: begin
            if (fill_ff == '0) begin
               state_in = ST_FIN;
            end else begin
               key_in   = rd_data;
               pos_in   = '0;
               state_in = ST_DN_L;
            end
         end
         ST_DN_L: begin
            if (left_idx >= fill_ext) begin
               wr_en    = 1'b1;
               state_in = ST_FIN;
            end else begin
               rd_addr  = left_idx[ADDR_W-1:0];
               state_in = ST_DN_R;
            end
         end
         ST_DN_R: begin
            lval_in      = rd_data;
            has_right_in = right_idx < fill_ext;
            if (right_idx < fill_ext) begin
               rd_addr = right_idx[ADDR_W-1:0];
            end
            state_in = ST_DN_CMP;
         end
         ST_DN_CMP: begin
            wr_en = 1'b1;
            if (key_ff > pick_val) begin
               wr_data  = pick_val;
               pos_in   = pick_idx[ADDR_W-1:0];
               state_in = ST_DN_L;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            rsp_valid_in   = 1'b1;
            rsp_status_in  = status_ff;
            rsp_removed_in = removed_ff;
            rsp_top_in     = (fill_ff == '0) ? '0 : top_ff;
            rsp_fill_in    = fill_ff;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // track the root slot so the minimum needs no extra read
   assign top_in = (wr_en && (wr_addr == '0)) ? wr_data : top_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff         <= pos_in;
      key_ff         <= key_in;
      lval_ff        <= lval_in;
      has_right_ff   <= has_right_in;
      top_ff         <= top_in;
      status_ff      <= status_in;
      removed_ff     <= removed_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_top_ff     <= rsp_top_in;
      rsp_fill_ff    <= rsp_fill_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_removed_key = rsp_removed_ff;
   assign rsp_top_key     = rsp_top_ff;
   assign rsp_fill        = rsp_fill_ff;

endmodule
`default_nettype wire

// File: rtl/core/bhq_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bhq_checker: port-level checks of the heap queue
// Watches transfers and results at the top-level ports; bound to the top.
// ----------------------------------------------------------------------------
module bhq_checker #(
   parameter int CAPACITY = 64
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          start,
   input wire logic                          busy,
   input wire logic                          rsp_valid,
   input wire bhq_pkg::status_type           rsp_status,
   input wire bhq_pkg::key_type              rsp_removed_key,
   input wire bhq_pkg::key_type              rsp_top_key,
   input wire logic [$clog2(CAPACITY+1)-1:0] rsp_fill
);

   localparam int FILL_W = $clog2(CAPACITY + 1);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("transfer accepted without going busy");

   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_fill <= FILL_W'(CAPACITY)))
      else $error("fill beyond capacity");

   a_empty_top: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_fill == '0)) |-> (rsp_top_key == '0))
      else $error("nonzero minimum on empty heap");

   a_empty_remove: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == bhq_pkg::STATUS_EMPTY))
         |-> ((rsp_removed_key == '0) && (rsp_fill == '0)))
      else $error("remove from empty heap reported data");

endmodule

bind binary_min_heap_queue_unit bhq_checker #(
   .CAPACITY(CAPACITY)
) u_bhq_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_status      (rsp_status),
   .rsp_removed_key (rsp_removed_key),
   .rsp_top_key     (rsp_top_key),
   .rsp_fill        (rsp_fill)
);
`default_nettype wire

// File: tb/tb_binary_min_heap_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_min_heap_queue_unit: self-checking bench of the min-heap queue
// A directed table covers empty removes, extreme keys, equal keys and filling
// to capacity. Random phases then lean toward fill or drain or stay balanced.
// Each result is checked against table values or a heap predictor alongside.
// ----------------------------------------------------------------------------
module tb_binary_min_heap_queue_unit;

   localparam int CAPACITY     = 64;
   localparam int FILL_W       = $clog2(CAPACITY + 1);
   localparam int RANDOM_OPS   = 590;
   localparam int CALM_TAIL    = 120;
   localparam int SETTLE       = 40;
   localparam int CYCLE_LIMIT  = 400000;
   localparam bhq_pkg::key_type KEY_MAX = 32'sh7FFFFFFF;
   localparam bhq_pkg::key_type KEY_MIN = 32'sh80000000;

   typedef struct {
      bhq_pkg::status_type status;
      bhq_pkg::key_type    removed_key;
      bhq_pkg::key_type    top_key;
      logic [FILL_W-1:0]   fill;
   } heap_result_type;

   typedef struct {
      logic              op;
      bhq_pkg::key_type  key;
      int                reps;
      int                key_step;
      bit                typed;
      heap_result_type   want;
   } stim_row_type;

   logic                clock;
   logic                reset     = 1'b1;
   logic                start     = 1'b0;
   logic                req_op    = bhq_pkg::OP_INSERT;
   bhq_pkg::key_type    req_key   = '0;
   logic                busy;
   logic                rsp_valid;
   bhq_pkg::status_type rsp_status;
   bhq_pkg::key_type    rsp_removed_key;
   bhq_pkg::key_type    rsp_top_key;
   logic [FILL_W-1:0]   rsp_fill;

   bhq_pkg::key_type    heap_keys [CAPACITY];
   int unsigned         key_count;
   heap_result_type     pending_results [$];
   stim_row_type        stim_rows [$];

   int unsigned         fault_count    = 0;
   int unsigned         checked_count  = 0;
   int unsigned         insert_count   = 0;
   int unsigned         remove_count   = 0;
   int unsigned         full_drops     = 0;
   int unsigned         empty_removes  = 0;
   int unsigned         full_reached   = 0;
   int unsigned         cycle_count    = 0;

   binary_min_heap_queue_unit #(
      .CAPACITY(CAPACITY)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_op(req_op),
      .req_key(req_key),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_removed_key(rsp_removed_key),
      .rsp_top_key(rsp_top_key),
      .rsp_fill(rsp_fill)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic heap_result_type apply_heap_op(input logic op,
                                                     input bhq_pkg::key_type key);
      heap_result_type  res;
      int unsigned      pos;
      int unsigned      parent;
      int unsigned      left;
      int unsigned      right;
      int unsigned      pick;
      bhq_pkg::key_type tmp;
      bit               done;
      res.status      = bhq_pkg::STATUS_OK;
      res.removed_key = '0;
      res.top_key     = '0;
      if (op == bhq_pkg::OP_INSERT) begin
         insert_count++;
         if (key_count >= CAPACITY) begin
            res.status = bhq_pkg::STATUS_FULL;
            full_drops++;
         end else begin
            heap_keys[key_count] = key;
            pos = key_count;
            key_count++;
            if (key_count == CAPACITY) full_reached++;
            done = 1'b0;
            while (pos != 0 && !done) begin
               parent = (pos - 1) / 2;
               if (heap_keys[parent] > heap_keys[pos]) begin
                  tmp               = heap_keys[parent];
                  heap_keys[parent] = heap_keys[pos];
                  heap_keys[pos]    = tmp;
                  pos               = parent;
               end else begin
                  done = 1'b1;
               end
            end
         end
      end else begin
         remove_count++;
         if (key_count == 0) begin
            res.status = bhq_pkg::STATUS_EMPTY;
            empty_removes++;
         end else begin
            res.removed_key = heap_keys[0];
            heap_keys[0]    = heap_keys[key_count - 1];
            key_count--;
            pos  = 0;
            done = 1'b0;
            while (!done) begin
               left  = 2 * pos + 1;
               right = left + 1;
               if (left >= key_count) begin
                  done = 1'b1;
               end else begin
                  if (right >= key_count || heap_keys[left] <= heap_keys[right])
                     pick = left;
                  else
                     pick = right;
                  if (heap_keys[pos] > heap_keys[pick]) begin
                     tmp             = heap_keys[pos];
                     heap_keys[pos]  = heap_keys[pick];
                     heap_keys[pick] = tmp;
                     pos             = pick;
                  end else begin
                     done = 1'b1;
                  end
               end
            end
         end
      end
      res.fill = FILL_W'(key_count);
      if (key_count > 0) res.top_key = heap_keys[0];
      return res;
   endfunction

   task automatic add_row(input logic op, input bhq_pkg::key_type key, input int reps,
                          input int key_step, input bit typed,
                          input bhq_pkg::status_type status,
                          input bhq_pkg::key_type removed_key,
                          input bhq_pkg::key_type top_key, input int fill);
      stim_row_type row;
      row.op               = op;
      row.key              = key;
      row.reps             = reps;
      row.key_step         = key_step;
      row.typed            = typed;
      row.want.status      = status;
      row.want.removed_key = removed_key;
      row.want.top_key     = top_key;
      row.want.fill        = FILL_W'(fill);
      stim_rows.push_back(row);
   endtask

   function automatic int pick_gap(input bit idle_on);
      if (idle_on && $urandom_range(0, 3) == 0) return $urandom_range(1, 16);
      return 0;
   endfunction

   // hold start low for the gap, then keep the request up until the transfer
   task automatic send_op(input logic op, input bhq_pkg::key_type key, input int gap,
                          input bit typed, input heap_result_type want);
      heap_result_type res;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start   <= 1'b1;
      req_op  <= op;
      req_key <= key;
      do @(posedge clock); while (busy);
      res = apply_heap_op(op, key);
      pending_results.push_back(typed ? want : res);
   endtask

   task automatic wait_for_drain();
      start <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic check_field(input string name, input logic signed [32:0] want_v,
                              input logic signed [32:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
         fault_count++;
      end
   endtask

   always @(posedge clock) begin : check_results
      heap_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result with no pending operation, status %0d fill %0d",
                     $time, rsp_status, rsp_fill);
            fault_count++;
         end else begin
            want = pending_results.pop_front();
            checked_count++;
            check_field("status", 33'(want.status), 33'(rsp_status));
            check_field("removed_key", 33'(want.removed_key), 33'(rsp_removed_key));
            check_field("top_key", 33'(want.top_key), 33'(rsp_top_key));
            check_field("fill", 33'(want.fill), 33'(rsp_fill));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: cycle limit reached with %0d results pending", $time,
                  pending_results.size());
         $display("simulation failed");
         $finish;
      end
   end

   initial begin : drive_ops
      heap_result_type  none;
      stim_row_type     row;
      logic             op;
      bhq_pkg::key_type key;
      int               sent;
      int               phase_left;
      int               insert_pct;
      bit               idle_on;
      bit               drained;
      none.status      = bhq_pkg::STATUS_OK;
      none.removed_key = '0;
      none.top_key     = '0;
      none.fill        = '0;
      key_count        = 0;
      foreach (heap_keys[i]) heap_keys[i] = '0;

      add_row(bhq_pkg::OP_REMOVE, 0, 1, 0, 1'b1, bhq_pkg::STATUS_EMPTY, 0, 0, 0);
      add_row(bhq_pkg::OP_INSERT, KEY_MAX, 1, 0, 1'b1, bhq_pkg::STATUS_OK, 0, KEY_MAX, 1);
      add_row(bhq_pkg::OP_INSERT, KEY_MIN, 1, 0, 1'b1, bhq_pkg::STATUS_OK, 0, KEY_MIN, 2);
      add_row(bhq_pkg::OP_REMOVE, 0, 1, 0, 1'b1, bhq_pkg::STATUS_OK, KEY_MIN, KEY_MAX, 1);
      add_row(bhq_pkg::OP_REMOVE, 0, 1, 0, 1'b1, bhq_pkg::STATUS_OK, KEY_MAX, 0, 0);
      add_row(bhq_pkg::OP_REMOVE, 0, 1, 0, 1'b1, bhq_pkg::STATUS_EMPTY, 0, 0, 0);
      add_row(bhq_pkg::OP_INSERT, 0, 1, 0, 1'b1, bhq_pkg::STATUS_OK, 0, 0, 1);
      add_row(bhq_pkg::OP_INSERT, -1, 1, 0, 1'b1, bhq_pkg::STATUS_OK, 0, -1, 2);
      add_row(bhq_pkg::OP_INSERT, 1, 1, 0, 1'b0, bhq_pkg::STATUS_OK, 0, 0, 0);
      add_row(bhq_pkg::OP_INSERT, -1, 1, 0, 1'b0, bhq_pkg::STATUS_OK, 0, 0, 0);
      add_row(bhq_pkg::OP_INSERT, 32'sh55555555, 1, 0, 1'b0, bhq_pkg::STATUS_OK, 0, 0, 0);
      add_row(bhq_pkg::OP_INSERT, 32'shAAAAAAAA, 1, 0, 1'b0, bhq_pkg::STATUS_OK, 0, 0, 0);
      add_row(bhq_pkg::OP_REMOVE, 0, 7, 0, 1'b0, bhq_pkg::STATUS_OK, 0, 0, 0);
      add_row(bhq_pkg::OP_INSERT, 1000, CAPACITY, -10, 1'b0, bhq_pkg::STATUS_OK, 0, 0, 0);
      add_row(bhq_pkg::OP_INSERT, 7, 1, 0, 1'b1, bhq_pkg::STATUS_FULL, 0, 370, CAPACITY);
      add_row(bhq_pkg::OP_INSERT, KEY_MIN, 1, 0, 1'b1, bhq_pkg::STATUS_FULL, 0, 370,
              CAPACITY);
      add_row(bhq_pkg::OP_REMOVE, 0, 1, 0, 1'b1, bhq_pkg::STATUS_OK, 370, 380,
              CAPACITY - 1);
      add_row(bhq_pkg::OP_INSERT, 5, 1, 0, 1'b0, bhq_pkg::STATUS_OK, 0, 0, 0);
      add_row(bhq_pkg::OP_INSERT, 5, 1, 0, 1'b1, bhq_pkg::STATUS_FULL, 0, 5, CAPACITY);
      add_row(bhq_pkg::OP_REMOVE, 0, CAPACITY, 0, 1'b0, bhq_pkg::STATUS_OK, 0, 0, 0);
      add_row(bhq_pkg::OP_REMOVE, 0, 1, 0, 1'b1, bhq_pkg::STATUS_EMPTY, 0, 0, 0);
      add_row(bhq_pkg::OP_INSERT, 3, 5, 0, 1'b0, bhq_pkg::STATUS_OK, 0, 0, 0);
      add_row(bhq_pkg::OP_REMOVE, 0, 5, 0, 1'b0, bhq_pkg::STATUS_OK, 0, 0, 0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_rows[i]) begin
         row = stim_rows[i];
         for (int r = 0; r < row.reps; r++)
            send_op(row.op, row.key + bhq_pkg::key_type'(r * row.key_step),
                    pick_gap(1'b1), row.typed, row.want);
      end

      sent       = 0;
      phase_left = 0;
      insert_pct = 50;
      idle_on    = 1'b0;
      drained    = 1'b0;
      while (sent < RANDOM_OPS) begin
         if (phase_left == 0) begin
            phase_left = $urandom_range(10, 90);
            case ($urandom_range(0, 2))
               0: insert_pct = 85;
               1: insert_pct = 15;
               default: insert_pct = 50;
            endcase
            idle_on = $urandom_range(0, 2) != 0;
         end
         if (!drained && sent >= RANDOM_OPS / 2) begin
            wait_for_drain();
            drained = 1'b1;
         end
         op = ($urandom_range(0, 99) < insert_pct) ? bhq_pkg::OP_INSERT : bhq_pkg::OP_REMOVE;
         case ($urandom_range(0, 3))
            0: key = $urandom_range(0, 8) - 4;
            1: begin
               case ($urandom_range(0, 3))
                  0: key = KEY_MAX;
                  1: key = KEY_MIN;
                  2: key = 0;
                  default: key = -1;
               endcase
            end
            default: key = bhq_pkg::key_type'($urandom);
         endcase
         send_op(op, key, pick_gap(idle_on && sent < RANDOM_OPS - CALM_TAIL), 1'b0, none);
         sent++;
         phase_left--;
      end

      wait_for_drain();
      repeat (SETTLE) @(posedge clock);
      $display("%0d results checked: %0d inserts (%0d dropped while full), %0d removes",
               checked_count, insert_count, full_drops, remove_count);
      $display("%0d removes on an empty heap, heap filled to capacity %0d times",
               empty_removes, full_reached);
      if (fault_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// File: binary_min_heap_queue_unit.f
rtl/core/bhq_pkg.sv
rtl/core/bhq_store.sv
rtl/core/binary_min_heap_queue_unit.sv
rtl/core/bhq_checker.sv
tb/tb_binary_min_heap_queue_unit.sv
